// File: hw/rtl/rplt_pkg.sv
// rplt_pkg: shared types and constants for the row peak line tracker.
// Beat structs, configuration, queue record and the result sequencer states.
// No dependencies.
package rplt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 8;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int CFG_IDX_BITS = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAD_THRESH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ROW_GAP  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_COL_GAP  = 3'd4;

    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [7:0]  RST_GRAD_THRESH  = 8'd25;
    localparam logic [9:0]  RST_MAX_ROW_GAP  = 10'd50;
    localparam logic [9:0]  RST_MAX_COL_GAP  = 10'd80;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_value;
        logic                  row_end;
        logic                  frame_end;
    } pixel_t;

    typedef struct packed {
        logic [9:0]  point_x;
        logic [10:0] point_y;
        logic        is_fallback;
        logic [10:0] point_total;
        logic        frame_last;
    } point_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [7:0]  gradient_threshold;
        logic [9:0]  max_row_gap;
        logic [9:0]  max_col_gap;
    } cfg_t;

    // one accepted pixel's worth of results: an optional line point,
    // an optional fallback pair, and the frame-end mark
    typedef struct packed {
        logic        pt_vld;
        logic [9:0]  pt_x;
        logic [10:0] pt_y;
        logic [10:0] total;
        logic        fb_vld;
        logic [9:0]  fb_x;
        logic [10:0] fb_y;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    typedef enum logic [1:0] {
        SEL_POINT,
        SEL_FB_LOW,
        SEL_FB_HIGH
    } sel_t;

endpackage

// File: hw/rtl/rplt_front.sv
// rplt_front: per-pixel row peak search, row close and frame end handling.
// Pushes one record per pixel beat that causes results. Uses rplt_pkg.
module rplt_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  rplt_pkg::cfg_t  cfg,
    input  logic            restart,
    input  logic [10:0]     restart_height,
    input  logic            pix_valid,
    input  rplt_pkg::pixel_t pix,
    input  rplt_pkg::qstat_t q_stat,
    output logic            pix_ready,
    output logic            push,
    output rplt_pkg::rec_t  rec
);

    localparam logic [rplt_pkg::COL_BITS-1:0] COL_LAST =
        rplt_pkg::COL_BITS'(rplt_pkg::MAX_WIDTH - 1);

    logic [rplt_pkg::COL_BITS-1:0]   col_reg, col_next;
    logic [rplt_pkg::ROW_BITS-1:0]   row_reg, row_next;
    logic [rplt_pkg::PIXEL_BITS-1:0] best_v_reg, best_v_next;
    logic [rplt_pkg::COL_BITS-1:0]   best_c_reg, best_c_next;
    logic [9:0]  prev_x_reg, prev_x_next;
    logic [10:0] prev_y_reg, prev_y_next;
    logic [10:0] acc_reg, acc_next;
    logic        stop_reg, stop_next;

    logic        accept, close, row_live, in_win, take, far, emit_pt, fallback;
    logic [10:0] h_src;
    logic [10:0] clamp_h;
    logic [rplt_pkg::ROW_BITS-1:0] row_start;
    logic [10:0] win_hi, gap;
    logic [9:0]  win_lo;
    logic [rplt_pkg::PIXEL_BITS-1:0] cand_v;
    logic [rplt_pkg::COL_BITS-1:0]   cand_c;
    logic [10:0] acc_new;

    assign pix_ready = !q_stat.full;
    assign accept    = pix_valid && pix_ready;
    assign close     = pix.row_end || pix.frame_end;

    // a height write restarts from the height being written
    assign h_src = restart ? restart_height : cfg.image_height;

    always_comb
    begin
        if (h_src < 11'd4)
            clamp_h = 11'd4;
        else if (h_src > 11'(rplt_pkg::MAX_HEIGHT))
            clamp_h = 11'(rplt_pkg::MAX_HEIGHT);
        else
            clamp_h = h_src;
    end
    assign row_start = rplt_pkg::ROW_BITS'(clamp_h - 11'd2);

    // column window: [max(1, prev-gap), prev+gap] once a point exists,
    // never past width-2
    assign win_hi = {1'b0, prev_x_reg} + {1'b0, cfg.max_col_gap};
    assign win_lo = (prev_x_reg > cfg.max_col_gap) ? (prev_x_reg - cfg.max_col_gap) : 10'd1;

    always_comb
    begin
        in_win = ({1'b0, col_reg} + 11'd2) <= cfg.image_width;
        if (acc_reg != 11'd0)
        begin
            if ({1'b0, col_reg} > win_hi)
                in_win = 1'b0;
            if (col_reg < win_lo)
                in_win = 1'b0;
        end
        else if (col_reg == '0)
        begin
            in_win = 1'b0;
        end
    end

    assign row_live = !stop_reg && (row_reg >= rplt_pkg::ROW_BITS'(2));
    assign take     = row_live && in_win && (pix.pixel_value > best_v_reg);
    assign cand_v   = take ? pix.pixel_value : best_v_reg;
    assign cand_c   = take ? col_reg : best_c_reg;

    assign gap = (prev_y_reg >= {1'b0, row_reg}) ? (prev_y_reg - {1'b0, row_reg})
                                                 : ({1'b0, row_reg} - prev_y_reg);
    assign far      = (acc_reg != 11'd0) && (gap > {1'b0, cfg.max_row_gap});
    assign emit_pt  = close && row_live && !far && (cand_v > cfg.gradient_threshold);
    assign acc_new  = (emit_pt && (acc_reg < clamp_h)) ? (acc_reg + 11'd1) : acc_reg;
    assign fallback = pix.frame_end && (acc_new < 11'd2);
    assign push     = accept && (emit_pt || fallback);

    always_comb
    begin
        rec.pt_vld = emit_pt;
        rec.pt_x   = 10'(cand_c);
        rec.pt_y   = {1'b0, row_reg} - 11'd1;
        rec.total  = acc_new;
        rec.fb_vld = fallback;
        rec.fb_x   = cfg.image_width[10:1];
        rec.fb_y   = cfg.image_height;
        rec.last   = pix.frame_end;
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        best_v_next = best_v_reg;
        best_c_next = best_c_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        acc_next    = acc_reg;
        stop_next   = stop_reg;
        if (restart || (accept && pix.frame_end))
        begin
            col_next    = '0;
            row_next    = row_start;
            best_v_next = '0;
            best_c_next = '0;
            prev_x_next = '0;
            prev_y_next = '0;
            acc_next    = '0;
            stop_next   = 1'b0;
        end
        else if (accept)
        begin
            if (close)
            begin
                if (close && row_live && far)
                    stop_next = 1'b1;
                if (emit_pt)
                begin
                    prev_x_next = 10'(cand_c);
                    prev_y_next = {1'b0, row_reg} - 11'd1;
                end
                acc_next    = acc_new;
                best_v_next = '0;
                best_c_next = '0;
                col_next    = '0;
                if (row_reg != '0)
                    row_next = row_reg - rplt_pkg::ROW_BITS'(1);
            end
            else
            begin
                best_v_next = cand_v;
                best_c_next = cand_c;
                if (col_reg < COL_LAST)
                    col_next = col_reg + rplt_pkg::COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= rplt_pkg::ROW_BITS'(rplt_pkg::RST_IMAGE_HEIGHT - 11'd2);
            best_v_reg <= '0;
            best_c_reg <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            acc_reg    <= '0;
            stop_reg   <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            best_v_reg <= best_v_next;
            best_c_reg <= best_c_next;
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            acc_reg    <= acc_next;
            stop_reg   <= stop_next;
        end
    end

endmodule

// File: hw/rtl/rplt_queue.sv
// rplt_queue: short record FIFO between the search front and the result back.
// Uses rplt_pkg for the record type and depth.
module rplt_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rplt_pkg::rec_t   wr_rec,
    input  logic             pop,
    output rplt_pkg::rec_t   head,
    output rplt_pkg::qstat_t stat
);

    localparam logic [rplt_pkg::QPTR_BITS:0] DEPTH = (rplt_pkg::QPTR_BITS+1)'(rplt_pkg::QDEPTH);

    rplt_pkg::rec_t                 mem_reg [rplt_pkg::QDEPTH];
    logic [rplt_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rplt_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rplt_pkg::QPTR_BITS:0]   cnt_reg, cnt_next;
    logic                           do_push, do_pop;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == DEPTH);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + rplt_pkg::QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + rplt_pkg::QPTR_BITS'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + (rplt_pkg::QPTR_BITS+1)'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - (rplt_pkg::QPTR_BITS+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/rplt_back.sv
// rplt_back: expands queued records into result beats, one per cycle
// unless point_ready stalls, via a registered output. Uses rplt_pkg.
module rplt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  rplt_pkg::rec_t   head,
    input  rplt_pkg::qstat_t q_stat,
    output logic             pop,
    output logic             point_valid,
    input  logic             point_ready,
    output rplt_pkg::point_t point
);

    rplt_pkg::sel_t   sel_reg, sel_next, eff_sel;
    rplt_pkg::point_t out_reg, out_next;
    logic             out_vld_reg, out_vld_next;
    logic             load;

    assign load    = !q_stat.empty && (!out_vld_reg || point_ready);
    assign eff_sel = ((sel_reg == rplt_pkg::SEL_POINT) && !head.pt_vld)
                     ? rplt_pkg::SEL_FB_LOW : sel_reg;

    // next state
    always_comb
    begin
        sel_next = sel_reg;
        if (load)
        begin
            case (eff_sel)
                rplt_pkg::SEL_POINT:   sel_next = head.fb_vld ? rplt_pkg::SEL_FB_LOW
                                                              : rplt_pkg::SEL_POINT;
                rplt_pkg::SEL_FB_LOW:  sel_next = rplt_pkg::SEL_FB_HIGH;
                rplt_pkg::SEL_FB_HIGH: sel_next = rplt_pkg::SEL_POINT;
                default:               sel_next = rplt_pkg::SEL_POINT;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        out_next.point_total = head.total;
        case (eff_sel)
            rplt_pkg::SEL_POINT:
            begin
                out_next.point_x     = head.pt_x;
                out_next.point_y     = head.pt_y;
                out_next.is_fallback = 1'b0;
                out_next.frame_last  = head.last && !head.fb_vld;
                pop                  = load && !head.fb_vld;
            end
            rplt_pkg::SEL_FB_LOW:
            begin
                out_next.point_x     = head.fb_x;
                out_next.point_y     = '0;
                out_next.is_fallback = 1'b1;
                out_next.frame_last  = 1'b0;
                pop                  = 1'b0;
            end
            rplt_pkg::SEL_FB_HIGH:
            begin
                out_next.point_x     = head.fb_x;
                out_next.point_y     = head.fb_y;
                out_next.is_fallback = 1'b1;
                out_next.frame_last  = head.last;
                pop                  = load;
            end
            default:
            begin
                out_next.point_x     = head.pt_x;
                out_next.point_y     = head.pt_y;
                out_next.is_fallback = 1'b0;
                out_next.frame_last  = 1'b0;
                pop                  = 1'b0;
            end
        endcase
        if (load)
            out_vld_next = 1'b1;
        else if (point_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg     <= rplt_pkg::SEL_POINT;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            sel_reg     <= sel_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign point_valid = out_vld_reg;
    assign point       = out_reg;

endmodule

// File: hw/rtl/row_peak_line_tracker.sv
// row_peak_line_tracker: top level, configuration registers and assertions.
// Instantiates rplt_front, rplt_queue and rplt_back; uses rplt_pkg.
//
// Gradient pixels stream in one beat per clock, row by row, starting at row
// image_height-2. For each row the front finds the first strict maximum in a
// column window around the previous line point and, at row end, emits the
// point (x, row-1) if the maximum beats gradient_threshold; a row gap above
// max_row_gap stops the search for the rest of the frame. At frame end with
// fewer than two points, a fallback pair (width/2, 0), (width/2, height)
// follows; frame_last marks the last result beat of the frame-end pixel.
// Throughput: one pixel beat per clock while pixel_ready is high, set by the
// combinational compare and window test in the front. A frame end with a
// point and a fallback pair yields three result beats; a four-record queue
// between front and back absorbs them, and pixel_ready drops only while
// the queue is full. The start row uses image_height clamped to 4..1024.
// cfg_ready is always high; configuration writes must be issued only while
// the block is idle. Writing image_height restarts the frame, other writes
// take effect at once.
module row_peak_line_tracker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    input  rplt_pkg::pixel_t                   pixel,
    output logic                               point_valid,
    input  logic                               point_ready,
    output rplt_pkg::point_t                   point,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rplt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [10:0]                        cfg_data
);

    rplt_pkg::cfg_t   cfg_reg, cfg_next;
    logic             cfg_wr, restart;
    logic             push, pop;
    rplt_pkg::rec_t   wr_rec, head;
    rplt_pkg::qstat_t q_stat;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && (cfg_index == rplt_pkg::CFG_IMAGE_HEIGHT);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                rplt_pkg::CFG_IMAGE_WIDTH:  cfg_next.image_width        = cfg_data;
                rplt_pkg::CFG_IMAGE_HEIGHT: cfg_next.image_height       = cfg_data;
                rplt_pkg::CFG_GRAD_THRESH:  cfg_next.gradient_threshold = cfg_data[7:0];
                rplt_pkg::CFG_MAX_ROW_GAP:  cfg_next.max_row_gap        = cfg_data[9:0];
                rplt_pkg::CFG_MAX_COL_GAP:  cfg_next.max_col_gap        = cfg_data[9:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width        <= rplt_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height       <= rplt_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.gradient_threshold <= rplt_pkg::RST_GRAD_THRESH;
            cfg_reg.max_row_gap        <= rplt_pkg::RST_MAX_ROW_GAP;
            cfg_reg.max_col_gap        <= rplt_pkg::RST_MAX_COL_GAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: search and classify each pixel beat
    rplt_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .restart        (restart),
        .restart_height (cfg_data),
        .pix_valid      (pixel_valid),
        .pix            (pixel),
        .q_stat         (q_stat),
        .pix_ready      (pixel_ready),
        .push           (push),
        .rec            (wr_rec)
    );

    rplt_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (wr_rec),
        .pop    (pop),
        .head   (head),
        .stat   (q_stat)
    );

    // back: result beats out of the queued records, one per cycle unless stalled
    rplt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point)
    );

    // a fallback beat only occurs with fewer than two accepted points
    a_fallback_total: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point.is_fallback |-> point.point_total < 11'd2)
        else $error("fallback beat with two or more accepted points");

    // a line point always counts itself
    a_point_counted: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point.is_fallback |-> point.point_total != 11'd0)
        else $error("line point with zero point total");

    // queue status is consistent
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue reports empty and full together");

    // a push never lands on a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("record pushed into full queue");

endmodule
